### design/bsc_pkg.sv
package bsc_pkg;

	// escape marker and the offset added to or taken from an escaped byte
	localparam logic [7:0] ESC_BYTE   = 8'h10;
	localparam logic [7:0] ESC_OFFSET = 8'h40;

	// bytes that need an escape in the body of a frame
	localparam logic [7:0] STX_BYTE  = 8'h02;
	localparam logic [7:0] ETX_BYTE  = 8'h03;
	localparam logic [7:0] XON_BYTE  = 8'h11;
	localparam logic [7:0] XOFF_BYTE = 8'h13;

	// direction register codes
	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	// default depth of the command queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// one command from the front to the back
	typedef struct packed {
		logic [7:0] data;  // byte to send (already offset for an escape pair)
		logic       pair;  // send ESC_BYTE first, then data
		logic       eof;   // last output of the frame
	} cmd_t;

	// queue status seen by both sides
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic needs_escape(input logic [7:0] b);
		needs_escape = (b == STX_BYTE) || (b == ETX_BYTE) || (b == ESC_BYTE) ||
			(b == XON_BYTE) || (b == XOFF_BYTE);
	endfunction

endpackage

### design/bsc_front.sv
module bsc_front
	import bsc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       direction,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       first_of_frame,
	input  logic       last_of_frame,
	input  q_status_t  q_status,
	output logic       push,
	output cmd_t       push_cmd
);

	logic pend_q;
	logic pend_d;
	logic accept;
	logic want_push;

	assign in_stall = q_status.full;
	assign accept   = in_valid && !q_status.full;
	assign push     = accept && want_push;

	always_comb begin
		pend_d        = pend_q;
		want_push     = 1'b1;
		push_cmd.data = data_byte;
		push_cmd.pair = 1'b0;
		push_cmd.eof  = last_of_frame;
		if (direction == DIR_ENCODE) begin
			pend_d = 1'b0;
			if (!first_of_frame && needs_escape(data_byte)) begin
				push_cmd.data = data_byte + ESC_OFFSET;
				push_cmd.pair = 1'b1;
			end
		end else if (first_of_frame || last_of_frame) begin
			pend_d = 1'b0;
		end else if (pend_q) begin
			pend_d        = 1'b0;
			push_cmd.data = data_byte - ESC_OFFSET;
		end else if (data_byte == ESC_BYTE) begin
			// body escape marker is dropped
			pend_d    = 1'b1;
			want_push = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (accept) begin
			pend_q <= pend_d;
		end
	end

	a_enc_clears_pend: assert property (@(posedge clk) disable iff (!arst_n)
		accept && direction == DIR_ENCODE |=> !pend_q)
		else $error("escape left pending in encode mode");

	a_drop_sets_pend: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !want_push |=> pend_q)
		else $error("dropped escape marker did not set pending flag");

	a_no_pair_decode: assert property (@(posedge clk) disable iff (!arst_n)
		push && direction == DIR_DECODE |-> !push_cmd.pair)
		else $error("escape pair produced in decode mode");

endmodule

### design/bsc_queue.sv
module bsc_queue
	import bsc_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  cmd_t      push_cmd,
	input  logic      pop,
	output cmd_t      head,
	output q_status_t q_status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_status.full  = (count_q == CNT_W'(DEPTH));
	assign q_status.empty = (count_q == '0);
	assign head           = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_status.full)
		else $error("push into full command queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("pop from empty command queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count above depth");

endmodule

### design/bsc_back.sv
module bsc_back
	import bsc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cmd_t       head,
	input  q_status_t  q_status,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	output logic       end_of_frame
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	logic       eof_q;
	logic       phase_q;   // escape marker of the head pair already sent
	logic       load;
	logic       send_esc;

	assign load     = (!out_valid_q || !out_stall) && !q_status.empty;
	assign send_esc = head.pair && !phase_q;
	assign pop      = load && !send_esc;

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign last_of_run  = last_q;
	assign end_of_frame = eof_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			phase_q     <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				phase_q     <= send_esc;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= send_esc ? ESC_BYTE : head.data;
			last_q     <= !send_esc;
			eof_q      <= send_esc ? 1'b0 : head.eof;
		end
	end

	a_esc_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !last_q |-> out_byte_q == ESC_BYTE && !eof_q)
		else $error("first half of escape pair malformed");

	a_pair_held: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> !q_status.empty && head.pair)
		else $error("escape pair head lost before second byte");

	a_phase_follows_esc: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q |-> out_valid_q && !last_q)
		else $error("pair phase set without escape marker on output");

endmodule

### design/byte_stuffing_codec.sv
// byte stuffing codec: escapes or unescapes a framed byte stream
//
// input channel: data_byte with first_of_frame / last_of_frame, in_valid,
//   in_stall; a transaction completes when in_valid is high and in_stall low
// output channel: out_byte, last_of_run, end_of_frame, out_valid, out_stall
// config channel: cfg_valid / cfg_ready / cfg_data write the direction bit
//   (0 encode, 1 decode); cfg_ready is always high, write only while idle
//
// an accepted byte passes through the command queue and the output register
// throughput: one input byte per cycle while in_stall is low; the output
//   register sends one byte per cycle while out_stall is low, so the queue
//   absorbs the extra byte of each encode-mode escape pair until it fills
// a body escape marker in decode mode produces no output transaction
// when out_stall is high the output register holds, the queue fills, and
//   in_stall rises once the queue is full
// reset clears the direction bit (encode), the pending escape flag, the
//   queue and the output valid
module byte_stuffing_codec
	import bsc_pkg::*;
#(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	// config write
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_data,
	// input stream
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] data_byte,
	input  logic       first_of_frame,
	input  logic       last_of_frame,
	// output stream
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	output logic       end_of_frame
);

	logic      direction_q;
	logic      push;
	logic      pop;
	cmd_t      push_cmd;
	cmd_t      head;
	q_status_t q_status;

	// direction register, writable at any time
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_ENCODE;
		end else if (cfg_valid && cfg_ready) begin
			direction_q <= cfg_data;
		end
	end

	// front: accepts bytes, tracks pending escape, decides what to send
	bsc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.direction      (direction_q),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.data_byte      (data_byte),
		.first_of_frame (first_of_frame),
		.last_of_frame  (last_of_frame),
		.q_status       (q_status),
		.push           (push),
		.push_cmd       (push_cmd)
	);

	// command queue decouples front from output backpressure
	bsc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_status (q_status)
	);

	// back: expands escape pairs into the output register
	bsc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_status     (q_status),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.last_of_run  (last_of_run),
		.end_of_frame (end_of_frame)
	);

endmodule
